/* rtl/key_press_qualifier_assert.svh */
// ---------------------------------------------------------------------------
// Key press qualifier assertion macros
// Assertion shorthands for the key press qualifier port checker.
// ---------------------------------------------------------------------------
`ifndef KEY_PRESS_QUALIFIER_ASSERT_SVH
`define KEY_PRESS_QUALIFIER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define KPQ_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("key press qualifier check failed");

// Next-cycle implication, disabled while reset is held.
`define KPQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("key press qualifier check failed");

`endif

/* rtl/kpq_pkg.sv */
// ---------------------------------------------------------------------------
// Key press qualifier package
// Phase codes, register map and fixed field widths.
// ---------------------------------------------------------------------------
package kpq_pkg;

  localparam int unsigned PHASE_BITS     = 3;
  localparam int unsigned CFG_ADDR_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS  = 32;
  localparam int unsigned REG_KEY_BITS   = 8;
  localparam int unsigned REG_TICK_BITS  = 16;
  localparam int unsigned EVENT_KEY_BITS = 8;

  // Phase codes.
  localparam logic [PHASE_BITS-1:0] PH_IDLE       = 3'd0;
  localparam logic [PHASE_BITS-1:0] PH_WAIT       = 3'd1;
  localparam logic [PHASE_BITS-1:0] PH_PRESSED    = 3'd2;
  localparam logic [PHASE_BITS-1:0] PH_SHORT      = 3'd3;
  localparam logic [PHASE_BITS-1:0] PH_SHORTWAIT  = 3'd4;
  localparam logic [PHASE_BITS-1:0] PH_LONG       = 3'd5;
  localparam logic [PHASE_BITS-1:0] PH_REPEATWAIT = 3'd6;

  // Register indexes.
  localparam logic [CFG_ADDR_BITS-1:0] REG_NO_KEY       = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_DEBOUNCE     = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_LONG_PRESS   = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_REPEAT       = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_RELEASE_WAIT = 3'd4;

  // Register reset values.
  localparam logic [REG_KEY_BITS-1:0]  RST_NO_KEY       = 8'd0;
  localparam logic [REG_TICK_BITS-1:0] RST_DEBOUNCE     = 16'd20;
  localparam logic [REG_TICK_BITS-1:0] RST_LONG_PRESS   = 16'd500;
  localparam logic [REG_TICK_BITS-1:0] RST_REPEAT       = 16'd80;
  localparam logic [REG_TICK_BITS-1:0] RST_RELEASE_WAIT = 16'd20;

endpackage

/* rtl/kpq_if.sv */
// ---------------------------------------------------------------------------
// Key press qualifier channels
// Valid/ready channels for samples, results and register writes.
// ---------------------------------------------------------------------------
interface kpq_in_if #(
  parameter int unsigned KEY_BITS = 8
);
  logic                valid;
  logic                ready;
  logic [KEY_BITS-1:0] key_sample;

  modport source (output valid, output key_sample, input ready);
  modport sink   (input valid, input key_sample, output ready);
endinterface

interface kpq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 press_event;
  logic                                 press_kind;
  logic [kpq_pkg::EVENT_KEY_BITS-1:0]   event_key;
  logic [kpq_pkg::PHASE_BITS-1:0]       phase_now;

  modport source (output valid, output press_event, output press_kind,
                  output event_key, output phase_now, input ready);
  modport sink   (input valid, input press_event, input press_kind,
                  input event_key, input phase_now, output ready);
endinterface

interface kpq_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [kpq_pkg::CFG_ADDR_BITS-1:0]   addr;
  logic [kpq_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

/* rtl/key_press_qualifier.sv */
// ---------------------------------------------------------------------------
// Key press qualifier
// Debounces a sampled key code and reports short, long and repeated presses.
// ---------------------------------------------------------------------------
// Each item on in_i is one timer tick carrying the sampled key code, and each
// item gives exactly one result on res_o: an event flag, its kind (short or
// long/repeat), the key of the event and the phase after the tick. The block
// takes one item per clock cycle while the consumer keeps ready high; an item
// is captured in an input register and its result moves into the result
// register when that register is empty or being drained, so the throughput
// is set only by the consumer's ready. The phase machine, the countdown timer
// and the latched key are updated when an item moves from the input register
// into the result register. Registers are written through cfg_i, which is
// always ready: 0 no-key code, 1 debounce ticks, 2 long-press ticks, 3 repeat
// ticks and 4 short-press release lockout; other indexes are ignored. Write
// them only while no item is in flight.
// ---------------------------------------------------------------------------
module key_press_qualifier #(
  parameter int unsigned KEY_BITS  = 8,
  parameter int unsigned TICK_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  kpq_in_if.sink        in_i,
  kpq_out_if.source     res_o,
  kpq_cfg_if.sink       cfg_i
);

  localparam int unsigned PB = kpq_pkg::PHASE_BITS;
  localparam int unsigned RK = kpq_pkg::REG_KEY_BITS;
  localparam int unsigned RT = kpq_pkg::REG_TICK_BITS;
  localparam int unsigned EK = kpq_pkg::EVENT_KEY_BITS;

  // Configuration registers.
  logic [RK-1:0] no_key_q;
  logic [RT-1:0] debounce_q;
  logic [RT-1:0] long_press_q;
  logic [RT-1:0] repeat_q;
  logic [RT-1:0] release_wait_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      no_key_q       <= kpq_pkg::RST_NO_KEY;
      debounce_q     <= kpq_pkg::RST_DEBOUNCE;
      long_press_q   <= kpq_pkg::RST_LONG_PRESS;
      repeat_q       <= kpq_pkg::RST_REPEAT;
      release_wait_q <= kpq_pkg::RST_RELEASE_WAIT;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.addr)
        kpq_pkg::REG_NO_KEY:       no_key_q       <= cfg_i.data[RK-1:0];
        kpq_pkg::REG_DEBOUNCE:     debounce_q     <= cfg_i.data[RT-1:0];
        kpq_pkg::REG_LONG_PRESS:   long_press_q   <= cfg_i.data[RT-1:0];
        kpq_pkg::REG_REPEAT:       repeat_q       <= cfg_i.data[RT-1:0];
        kpq_pkg::REG_RELEASE_WAIT: release_wait_q <= cfg_i.data[RT-1:0];
        default: ;
      endcase
    end
  end

  // Register values resized to the key and timer widths of this instance.
  logic [KEY_BITS+RK-1:0]  no_key_ext;
  logic [TICK_BITS+RT-1:0] debounce_ext;
  logic [TICK_BITS+RT-1:0] long_press_ext;
  logic [TICK_BITS+RT-1:0] repeat_ext;
  logic [TICK_BITS+RT-1:0] release_wait_ext;
  logic [KEY_BITS-1:0]     no_key;

  assign no_key_ext       = {{KEY_BITS{1'b0}}, no_key_q};
  assign debounce_ext     = {{TICK_BITS{1'b0}}, debounce_q};
  assign long_press_ext   = {{TICK_BITS{1'b0}}, long_press_q};
  assign repeat_ext       = {{TICK_BITS{1'b0}}, repeat_q};
  assign release_wait_ext = {{TICK_BITS{1'b0}}, release_wait_q};
  assign no_key           = no_key_ext[KEY_BITS-1:0];

  // Input register and handshake. The result register frees up when it is
  // empty or being drained; the input register moves forward at that time.
  logic                s1_valid_q;
  logic [KEY_BITS-1:0] s1_key_q;
  logic                res_valid_q;
  logic                out_free;
  logic                step;

  assign out_free   = !res_valid_q || res_o.ready;
  assign step       = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_key_q <= in_i.key_sample;
    end
  end

  // Phase machine state.
  logic [PB-1:0]        phase_q, phase_d;
  logic [TICK_BITS-1:0] cnt_q, cnt_d;
  logic                 run_q, run_d;
  logic [KEY_BITS-1:0]  held_q, held_d;

  logic [TICK_BITS-1:0] cnt_dec;
  logic                 down;
  logic                 expired;
  logic [KEY_BITS-1:0]  ev_key;

  always_comb begin
    down = s1_key_q != no_key;

    // The timer counts down first; it expires when running and at zero.
    cnt_dec = cnt_q;
    if (run_q && (cnt_q != '0)) begin
      cnt_dec = cnt_q - {{(TICK_BITS-1){1'b0}}, 1'b1};
    end
    expired = run_q && (cnt_dec == '0);

    held_d = held_q;
    if ((phase_q == kpq_pkg::PH_IDLE) && down) begin
      held_d = s1_key_q;
    end

    phase_d = phase_q;
    cnt_d   = cnt_dec;
    run_d   = run_q;
    ev_key  = s1_key_q;

    unique case (phase_q)
      kpq_pkg::PH_IDLE: begin
        if (down) begin
          cnt_d   = debounce_ext[TICK_BITS-1:0];
          run_d   = 1'b1;
          phase_d = kpq_pkg::PH_WAIT;
        end
      end
      kpq_pkg::PH_WAIT: begin
        if (expired) begin
          run_d = 1'b0;
          if (down) begin
            cnt_d   = long_press_ext[TICK_BITS-1:0];
            run_d   = 1'b1;
            phase_d = kpq_pkg::PH_PRESSED;
          end else begin
            phase_d = kpq_pkg::PH_IDLE;
          end
        end
      end
      kpq_pkg::PH_PRESSED: begin
        if (expired) begin
          run_d   = 1'b0;
          phase_d = kpq_pkg::PH_LONG;
        end else if (!down) begin
          ev_key  = held_d;
          phase_d = kpq_pkg::PH_SHORT;
        end
      end
      kpq_pkg::PH_SHORT: begin
        cnt_d   = release_wait_ext[TICK_BITS-1:0];
        run_d   = 1'b1;
        phase_d = kpq_pkg::PH_SHORTWAIT;
      end
      kpq_pkg::PH_SHORTWAIT: begin
        if (expired) begin
          run_d   = 1'b0;
          phase_d = kpq_pkg::PH_IDLE;
        end
      end
      kpq_pkg::PH_LONG: begin
        cnt_d   = repeat_ext[TICK_BITS-1:0];
        run_d   = 1'b1;
        phase_d = kpq_pkg::PH_REPEATWAIT;
      end
      kpq_pkg::PH_REPEATWAIT: begin
        if (expired) begin
          run_d   = 1'b0;
          ev_key  = held_d;
          phase_d = kpq_pkg::PH_LONG;
        end else if (!down) begin
          phase_d = kpq_pkg::PH_IDLE;
        end
      end
      default: begin
        // The unused code falls back to idle without an event.
        phase_d = kpq_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= kpq_pkg::PH_IDLE;
      cnt_q   <= '0;
      run_q   <= 1'b0;
      held_q  <= '0;
    end else if (step) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      run_q   <= run_d;
      held_q  <= held_d;
    end
  end

  // Result register.
  logic                fire;
  logic [KEY_BITS+EK-1:0] ev_key_ext;
  logic                event_q;
  logic                kind_q;
  logic [EK-1:0]       event_key_q;
  logic [PB-1:0]       phase_now_q;

  assign fire       = (phase_d == kpq_pkg::PH_SHORT) || (phase_d == kpq_pkg::PH_LONG);
  assign ev_key_ext = {{EK{1'b0}}, ev_key};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_free) begin
      res_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      event_q     <= fire;
      kind_q      <= phase_d == kpq_pkg::PH_LONG;
      event_key_q <= fire ? ev_key_ext[EK-1:0] : '0;
      phase_now_q <= phase_d;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.press_event = event_q;
  assign res_o.press_kind  = kind_q;
  assign res_o.event_key   = event_key_q;
  assign res_o.phase_now   = phase_now_q;

endmodule

/* rtl/kpq_checker.sv */
// ---------------------------------------------------------------------------
// Key press qualifier checker
// Port-level checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "key_press_qualifier_assert.svh"

module kpq_port_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                res_valid_i,
  input logic                                res_ready_i,
  input logic                                press_event_i,
  input logic                                press_kind_i,
  input logic [kpq_pkg::EVENT_KEY_BITS-1:0]  event_key_i,
  input logic [kpq_pkg::PHASE_BITS-1:0]      phase_now_i
);

  // An event is reported exactly in the short and long phases.
  `KPQ_ASSERT_NOW(a_event_phase, clk_i, rst_ni, res_valid_i, press_event_i == ((phase_now_i == kpq_pkg::PH_SHORT) || (phase_now_i == kpq_pkg::PH_LONG)))

  // Without an event, kind and key read as zero.
  `KPQ_ASSERT_NOW(a_quiet_zero, clk_i, rst_ni, res_valid_i && !press_event_i, !press_kind_i && (event_key_i == '0))

  // A long kind only appears with the long phase.
  `KPQ_ASSERT_NOW(a_kind_long, clk_i, rst_ni, res_valid_i && press_kind_i, phase_now_i == kpq_pkg::PH_LONG)

  // A stalled result holds.
  `KPQ_ASSERT_NEXT(a_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(phase_now_i) && $stable(event_key_i))

endmodule

bind key_press_qualifier kpq_port_checker u_kpq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .press_event_i (res_o.press_event),
  .press_kind_i  (res_o.press_kind),
  .event_key_i   (res_o.event_key),
  .phase_now_i   (res_o.phase_now)
);

/* sim/kpq_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Key press qualifier checker
// Watches the sample, result and register channels, predicts the result of
// every accepted item and compares it field by field.
// ---------------------------------------------------------------------------
module kpq_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               tick_valid_i,
  input  logic                               tick_ready_i,
  input  logic [kpq_pkg::REG_KEY_BITS-1:0]   tick_key_i,
  input  logic                               res_valid_i,
  input  logic                               res_ready_i,
  input  logic                               res_event_i,
  input  logic                               res_kind_i,
  input  logic [kpq_pkg::EVENT_KEY_BITS-1:0] res_key_i,
  input  logic [kpq_pkg::PHASE_BITS-1:0]     res_phase_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [kpq_pkg::CFG_ADDR_BITS-1:0]  cfg_addr_i,
  input  logic [kpq_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 short_count_o,
  output int                                 long_count_o
);

  typedef struct packed {
    logic                               press_event;
    logic                               press_kind;
    logic [kpq_pkg::EVENT_KEY_BITS-1:0] event_key;
    logic [kpq_pkg::PHASE_BITS-1:0]     phase_now;
  } tick_result_t;

  // Register copies.
  logic [kpq_pkg::REG_KEY_BITS-1:0]  no_key_q;
  logic [kpq_pkg::REG_TICK_BITS-1:0] debounce_q;
  logic [kpq_pkg::REG_TICK_BITS-1:0] long_press_q;
  logic [kpq_pkg::REG_TICK_BITS-1:0] repeat_q;
  logic [kpq_pkg::REG_TICK_BITS-1:0] release_wait_q;

  // Predicted machine state.
  logic [kpq_pkg::PHASE_BITS-1:0]    phase_q;
  logic [kpq_pkg::REG_TICK_BITS-1:0] countdown_q;
  logic                              running_q;
  logic [kpq_pkg::REG_KEY_BITS-1:0]  held_key_q;

  tick_result_t expected_results[$];
  int fails;
  int shorts;
  int longs;
  int pending;
  int result_index;

  assign fail_count_o  = fails;
  assign pending_o     = pending;
  assign short_count_o = shorts;
  assign long_count_o  = longs;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    fails++;
    if (fails <= 100) begin
      $display("[%0t] result %0d: %s is %0d, expected %0d", $realtime, result_index,
               what, got, want);
    end
  endtask

  function automatic void start_countdown(input logic [kpq_pkg::REG_TICK_BITS-1:0] ticks);
    countdown_q = ticks;
    running_q   = 1'b1;
  endfunction

  // A check of the timer consumes the expiry.
  function automatic logic countdown_expired();
    logic hit;
    hit = running_q && (countdown_q == '0);
    if (hit) begin
      running_q = 1'b0;
    end
    return hit;
  endfunction

  function automatic tick_result_t qualify_tick(input logic [kpq_pkg::REG_KEY_BITS-1:0] key);
    tick_result_t res;
    logic [kpq_pkg::EVENT_KEY_BITS-1:0] ev_key;
    logic down;
    ev_key = key;
    down   = (key != no_key_q);
    if (running_q && countdown_q != '0) begin
      countdown_q = countdown_q - 16'd1;
    end
    if (phase_q == kpq_pkg::PH_IDLE && down) begin
      held_key_q = key;
    end
    case (phase_q)
      kpq_pkg::PH_IDLE: begin
        if (down) begin
          start_countdown(debounce_q);
          phase_q = kpq_pkg::PH_WAIT;
        end
      end
      kpq_pkg::PH_WAIT: begin
        if (countdown_expired()) begin
          if (down) begin
            start_countdown(long_press_q);
            phase_q = kpq_pkg::PH_PRESSED;
          end else begin
            phase_q = kpq_pkg::PH_IDLE;
          end
        end
      end
      kpq_pkg::PH_PRESSED: begin
        if (countdown_expired()) begin
          phase_q = kpq_pkg::PH_LONG;
        end else if (!down) begin
          ev_key  = held_key_q;
          phase_q = kpq_pkg::PH_SHORT;
        end
      end
      kpq_pkg::PH_SHORT: begin
        phase_q = kpq_pkg::PH_SHORTWAIT;
        start_countdown(release_wait_q);
      end
      kpq_pkg::PH_SHORTWAIT: begin
        if (countdown_expired()) begin
          phase_q = kpq_pkg::PH_IDLE;
        end
      end
      kpq_pkg::PH_LONG: begin
        start_countdown(repeat_q);
        phase_q = kpq_pkg::PH_REPEATWAIT;
      end
      kpq_pkg::PH_REPEATWAIT: begin
        if (countdown_expired()) begin
          ev_key  = held_key_q;
          phase_q = kpq_pkg::PH_LONG;
        end else if (!down) begin
          phase_q = kpq_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_q = kpq_pkg::PH_IDLE;
      end
    endcase
    res = '0;
    res.phase_now = phase_q;
    if (phase_q == kpq_pkg::PH_SHORT || phase_q == kpq_pkg::PH_LONG) begin
      res.press_event = 1'b1;
      res.press_kind  = (phase_q == kpq_pkg::PH_LONG);
      res.event_key   = ev_key;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tick_result_t got;
    tick_result_t want;
    if (!rst_ni) begin
      no_key_q       = kpq_pkg::RST_NO_KEY;
      debounce_q     = kpq_pkg::RST_DEBOUNCE;
      long_press_q   = kpq_pkg::RST_LONG_PRESS;
      repeat_q       = kpq_pkg::RST_REPEAT;
      release_wait_q = kpq_pkg::RST_RELEASE_WAIT;
      phase_q        = kpq_pkg::PH_IDLE;
      countdown_q    = '0;
      running_q      = 1'b0;
      held_key_q     = '0;
      expected_results.delete();
      fails        = 0;
      shorts       = 0;
      longs        = 0;
      pending      = 0;
      result_index = 0;
    end else begin
      // Results first: a result can never belong to an item taken in this cycle.
      if (res_valid_i && res_ready_i) begin
        got.press_event = res_event_i;
        got.press_kind  = res_kind_i;
        got.event_key   = res_key_i;
        got.phase_now   = res_phase_i;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending, phase", 32'(got.phase_now), 0);
        end else begin
          want = expected_results.pop_front();
          if (got.press_event !== want.press_event)
            report_mismatch("press_event", 32'(got.press_event), 32'(want.press_event));
          if (got.press_kind !== want.press_kind)
            report_mismatch("press_kind", 32'(got.press_kind), 32'(want.press_kind));
          if (got.event_key !== want.event_key)
            report_mismatch("event_key", 32'(got.event_key), 32'(want.event_key));
          if (got.phase_now !== want.phase_now)
            report_mismatch("phase_now", 32'(got.phase_now), 32'(want.phase_now));
          if (want.press_event && want.press_kind) longs++;
          else if (want.press_event) shorts++;
        end
        result_index++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_addr_i)
          kpq_pkg::REG_NO_KEY:
            no_key_q       = cfg_data_i[kpq_pkg::REG_KEY_BITS-1:0];
          kpq_pkg::REG_DEBOUNCE:
            debounce_q     = cfg_data_i[kpq_pkg::REG_TICK_BITS-1:0];
          kpq_pkg::REG_LONG_PRESS:
            long_press_q   = cfg_data_i[kpq_pkg::REG_TICK_BITS-1:0];
          kpq_pkg::REG_REPEAT:
            repeat_q       = cfg_data_i[kpq_pkg::REG_TICK_BITS-1:0];
          kpq_pkg::REG_RELEASE_WAIT:
            release_wait_q = cfg_data_i[kpq_pkg::REG_TICK_BITS-1:0];
          default: ;
        endcase
      end
      if (tick_valid_i && tick_ready_i) begin
        expected_results.push_back(qualify_tick(tick_key_i));
      end
      pending = expected_results.size();
    end
  end

endmodule

/* sim/tb_key_press_qualifier.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Key press qualifier testbench
// Drives key samples and register writes into the qualifier, stalls both
// channels at random and lets the checker predict and compare every result.
// ---------------------------------------------------------------------------
module tb_key_press_qualifier;

  // An index the block has no register for; writes to it must be ignored.
  localparam logic [kpq_pkg::CFG_ADDR_BITS-1:0] REG_SPARE = 3'd7;

  // Cycles without any handshake before the run is declared hung. The
  // longest legal quiet stretch is the deliberate consumer hold-off below.
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES = 8;

  logic clk;
  logic rst_n;

  kpq_in_if #(.KEY_BITS(kpq_pkg::REG_KEY_BITS)) tick_ch ();
  kpq_out_if res_ch ();
  kpq_cfg_if cfg_ch ();

  key_press_qualifier #(
    .KEY_BITS (kpq_pkg::REG_KEY_BITS),
    .TICK_BITS(kpq_pkg::REG_TICK_BITS)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (tick_ch),
    .res_o (res_ch),
    .cfg_i (cfg_ch)
  );

  int fail_count;
  int pending;
  int short_count;
  int long_count;

  kpq_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .tick_valid_i (tick_ch.valid),
    .tick_ready_i (tick_ch.ready),
    .tick_key_i   (tick_ch.key_sample),
    .res_valid_i  (res_ch.valid),
    .res_ready_i  (res_ch.ready),
    .res_event_i  (res_ch.press_event),
    .res_kind_i   (res_ch.press_kind),
    .res_key_i    (res_ch.event_key),
    .res_phase_i  (res_ch.phase_now),
    .cfg_valid_i  (cfg_ch.valid),
    .cfg_ready_i  (cfg_ch.ready),
    .cfg_addr_i   (cfg_ch.addr),
    .cfg_data_i   (cfg_ch.data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .short_count_o(short_count),
    .long_count_o (long_count)
  );

  // Shadow of the register settings, used only to shape the key gestures.
  logic [kpq_pkg::REG_KEY_BITS-1:0] no_key_now = kpq_pkg::RST_NO_KEY;
  int debounce_now     = int'(kpq_pkg::RST_DEBOUNCE);
  int long_press_now   = int'(kpq_pkg::RST_LONG_PRESS);
  int repeat_now       = int'(kpq_pkg::RST_REPEAT);
  int release_wait_now = int'(kpq_pkg::RST_RELEASE_WAIT);

  bit idling_on = 1'b1;   // random gaps on both sides while set
  bit hold_req  = 1'b0;   // asks the consumer for one long hold-off
  int items_sent = 0;
  int settings_run = 1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Consumer side. Ready drops in short random bursts while idling is on.
  // On request it holds off for a long stretch so that the block fills up
  // and has to stall the sample channel.
  initial begin
    int stall_left;
    int held;
    stall_left = 0;
    held = 0;
    res_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        held++;
        if (held >= HOLD_CYCLES) begin
          held = 0;
          hold_req = 1'b0;
        end
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 6);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: counts cycles in which no channel moves anything.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Offers one sample, sometimes after a random gap, and waits until it is
  // taken. Valid stays high afterwards so back-to-back items need no toggle.
  task automatic send_tick(input logic [kpq_pkg::REG_KEY_BITS-1:0] key);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    tick_ch.valid      <= 1'b1;
    tick_ch.key_sample <= key;
    do @(posedge clk); while (!tick_ch.ready);
    items_sent++;
  endtask

  // One register write. Valid is left high; the caller lowers it after the
  // last write of a batch.
  task automatic write_reg(input logic [kpq_pkg::CFG_ADDR_BITS-1:0] addr,
                           input logic [kpq_pkg::CFG_DATA_BITS-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= addr;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Writes all five registers. The unused upper data bits carry noise,
  // which the block has to drop.
  task automatic apply_settings(input logic [kpq_pkg::REG_KEY_BITS-1:0] no_key,
                                input logic [kpq_pkg::REG_TICK_BITS-1:0] debounce,
                                input logic [kpq_pkg::REG_TICK_BITS-1:0] long_press,
                                input logic [kpq_pkg::REG_TICK_BITS-1:0] repeat_period,
                                input logic [kpq_pkg::REG_TICK_BITS-1:0] release_wait);
    logic [kpq_pkg::CFG_DATA_BITS-1:0] noise;
    noise = $urandom();
    write_reg(kpq_pkg::REG_NO_KEY, {noise[31:8], no_key});
    write_reg(kpq_pkg::REG_DEBOUNCE, {noise[31:16], debounce});
    write_reg(kpq_pkg::REG_LONG_PRESS, {noise[15:0], long_press});
    write_reg(kpq_pkg::REG_REPEAT, {noise[23:8], repeat_period});
    write_reg(kpq_pkg::REG_RELEASE_WAIT, {noise[27:12], release_wait});
    cfg_ch.valid <= 1'b0;
    no_key_now       = no_key;
    debounce_now     = int'(debounce);
    long_press_now   = int'(long_press);
    repeat_now       = int'(repeat_period);
    release_wait_now = int'(release_wait);
    settings_run++;
  endtask

  // Stops offering samples, waits for every pending result and then a few
  // cycles more, so that the block is idle for register writes.
  task automatic drain();
    tick_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [kpq_pkg::REG_KEY_BITS-1:0] pick_key();
    logic [kpq_pkg::REG_KEY_BITS-1:0] key;
    do key = 8'($urandom_range(0, 255)); while (key == no_key_now);
    return key;
  endfunction

  // One key gesture: mostly a clean press of a length aimed at a bounce, a
  // short press or a long press with repeats, followed by a release. Some
  // presses glitch to another code mid-hold; a few gestures are pure noise.
  task automatic key_gesture();
    logic [kpq_pkg::REG_KEY_BITS-1:0] key;
    int debounce;
    int long_press;
    int repeat_period;
    int release_wait;
    int hold;
    int rest;
    int mode;
    debounce      = (debounce_now == 0) ? 1 : debounce_now;
    long_press    = (long_press_now == 0) ? 1 : long_press_now;
    repeat_period = (repeat_now == 0) ? 1 : repeat_now;
    release_wait  = (release_wait_now == 0) ? 1 : release_wait_now;
    key  = pick_key();
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      repeat ($urandom_range(1, 12)) begin
        send_tick($urandom_range(0, 3) == 0 ? no_key_now : 8'($urandom_range(0, 255)));
      end
    end else begin
      if (mode <= 2) hold = $urandom_range(1, debounce + 1);
      else if (mode <= 5) hold = debounce + 1 + $urandom_range(0, long_press + 1);
      else hold = debounce + long_press + 2 + $urandom_range(0, 3 * (repeat_period + 1));
      if (hold > 40) hold = $urandom_range(30, 40);
      repeat (hold) begin
        send_tick($urandom_range(0, 15) == 0 ? 8'($urandom_range(0, 255)) : key);
      end
      rest = $urandom_range(0, release_wait + debounce + 4);
      if (rest > 30) rest = $urandom_range(20, 30);
      repeat (rest) send_tick(no_key_now);
    end
  endtask

  task automatic run_gestures(input int target);
    int first;
    first = items_sent;
    while (items_sent - first < target) key_gesture();
  endtask

  initial begin
    rst_n              = 1'b0;
    tick_ch.valid      <= 1'b0;
    tick_ch.key_sample <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.addr        <= kpq_pkg::REG_NO_KEY;
    cfg_ch.data        <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: only bounces and short presses fit in this stretch.
    run_gestures(80);
    drain();

    // Directed part with no-key at the top code and zero periods, which act
    // like one tick. A write to an index without a register comes first.
    write_reg(REG_SPARE, $urandom());
    apply_settings(8'hFF, 16'd0, 16'd2, 16'd0, 16'd0);
    // Lowest code confirmed, then released: a short press.
    send_tick(8'hFF);
    send_tick(8'h00);
    send_tick(8'h00);
    send_tick(8'hFF);
    send_tick(8'hFF);
    send_tick(8'hFF);
    // Released during the debounce wait: no event.
    send_tick(8'h5A);
    send_tick(8'hFF);
    send_tick(8'hFF);
    // Held into a long press while the code changes: the long event takes
    // the current sample, the repeats take the latched key.
    send_tick(8'hFE);
    send_tick(8'hFE);
    send_tick(8'hFE);
    send_tick(8'h01);
    send_tick(8'h01);
    send_tick(8'h01);
    send_tick(8'h01);
    send_tick(8'h01);
    send_tick(8'hFF);
    send_tick(8'hFF);
    drain();

    for (int s = 0; s < 6; s++) begin
      case (s)
        0: begin
          apply_settings(8'h00, 16'd1, 16'd1, 16'd1, 16'd1);
          run_gestures(150);
        end
        1: begin
          apply_settings(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          run_gestures(40);
        end
        default: begin
          apply_settings(8'($urandom_range(0, 255)), 16'($urandom_range(0, 6)),
                         16'($urandom_range(0, 8)), 16'($urandom_range(0, 5)),
                         16'($urandom_range(0, 6)));
          // The consumer goes quiet while samples keep coming.
          if (s == 2) hold_req = 1'b1;
          run_gestures(150);
        end
      endcase
      drain();
    end

    // Last stretch runs at full rate on both sides.
    idling_on = 1'b0;
    apply_settings(8'($urandom_range(0, 255)), 16'($urandom_range(1, 4)),
                   16'($urandom_range(1, 6)), 16'($urandom_range(1, 3)),
                   16'($urandom_range(1, 4)));
    run_gestures(160);
    drain();

    @(negedge clk);
    $display("covered %0d samples under %0d register settings", items_sent, settings_run);
    $display("saw %0d short and %0d long or repeat events", short_count, long_count);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
